/* rtl/wcss_pkg.sv */
package wcss_pkg;

    localparam int TEMP_WIDTH      = 16;
    localparam int FILM_WIDTH      = TEMP_WIDTH + 1;
    localparam int TABLE_POINTS    = 10;
    localparam int EXTRAP_SEGMENTS = 16;
    localparam int BREAKPOINTS     = TABLE_POINTS + EXTRAP_SEGMENTS;
    localparam int FACES           = 6;
    localparam int SCALE_WIDTH     = 40;
    localparam int K_WIDTH         = 18;
    localparam int HEAT_WIDTH      = 48;

    // film temperature breakpoints in Q12.5 kelvin
    localparam int FILM_300K  = 9600;
    localparam int TABLE_STEP = 3200;
    localparam int ROM_STEP   = 6400;
    localparam int TABLE_TOP  = FILM_300K + TABLE_STEP * (TABLE_POINTS - 1);

    // reciprocal of 25 for the interpolation divide, 2^32 scaled, rounded up
    localparam logic [27:0] RECIP_25 = 28'd171798692;

    // conductivity at each breakpoint, Q0.20
    localparam logic [K_WIDTH-1:0] COND_K [BREAKPOINTS] = '{
        18'd27473, 18'd34970, 18'd41775, 18'd48025, 18'd53687,
        18'd58825, 18'd63649, 18'd67948, 18'd71827, 18'd75330,
        18'd82375, 18'd89008, 18'd95301, 18'd101307, 18'd107065,
        18'd112607, 18'd117958, 18'd123138, 18'd128166, 18'd133054,
        18'd137816, 18'd142461, 18'd146999, 18'd151438, 18'd155785,
        18'd160046
    };

    // register indexes
    localparam logic [1:0] REG_X_SCALE = 2'd0;
    localparam logic [1:0] REG_Y_SCALE = 2'd1;
    localparam logic [1:0] REG_Z_SCALE = 2'd2;

    typedef struct packed {
        logic [15:0] center_temp;
        logic [15:0] temp_x_plus;
        logic [15:0] temp_x_minus;
        logic [15:0] temp_y_plus;
        logic [15:0] temp_y_minus;
        logic [15:0] temp_z_plus;
        logic [15:0] temp_z_minus;
        logic        center_fluid;
        logic [5:0]  wall_mask;
    } cell_in_t;

    typedef struct packed {
        logic signed [47:0] heat_rate;
        logic               saturated;
    } heat_out_t;

    // breakpoint position in Q12.5 kelvin
    function automatic logic [FILM_WIDTH:0] seg_base(input int j);
        if (j < TABLE_POINTS) begin
            return (FILM_WIDTH + 1)'(FILM_300K + TABLE_STEP * j);
        end
        return (FILM_WIDTH + 1)'(TABLE_TOP + ROM_STEP * (j - (TABLE_POINTS - 1)));
    endfunction

endpackage

/* rtl/wall_conduction_source_stencil_core.sv */
// Wall conduction source for one grid cell per transfer.
// Input channel s_valid/s_ready/s_data carries the cell temperature, six
// neighbour temperatures, the fluid flag and the wall mask. Result channel
// m_valid/m_ready/m_data carries heat_rate (signed Q31.16) and saturated.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// x, y and z axis scales (index 0, 1, 2; other indexes are dropped); it is
// always ready and must be written only while the block is empty.
// One cell is taken every cycle while the result channel is not stalled.
// The twelve register stages run six face lanes side by
// side: film sum, segment select, slope product, divide by reciprocal,
// conductivity, k*dT, scale split into two 34x20 products, signed term,
// two adder levels and the round/saturate stage.
// Each stage holds while the one after it is full and stalled, so a stalled
// receiver fills the bubbles first and then holds s_ready low; nothing is
// lost or repeated. Synchronous active-low reset empties the pipeline and
// clears the three scales to zero.
module wall_conduction_source_stencil_core
    import wcss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cell_in_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output heat_out_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [SCALE_WIDTH-1:0] cfg_data
);

    localparam int STAGES   = 12;
    localparam int OFF_W    = 13;
    localparam int DK_W     = 13;
    localparam int X_W      = 26;
    localparam int Y_W      = 19;
    localparam int PROD_W   = Y_W + 28;
    localparam int MAG_W    = K_WIDTH + TEMP_WIDTH;
    localparam int HALF_W   = SCALE_WIDTH / 2;
    localparam int PART_W   = MAG_W + HALF_W;
    localparam int TERM_W   = MAG_W + SCALE_WIDTH + 1;
    localparam int PAIR_W   = TERM_W + 1;
    localparam int ACC_W    = TERM_W + 4;
    localparam int SH_W     = ACC_W - 16;

    logic [SCALE_WIDTH-1:0] scale_reg [3];
    logic [STAGES:1]        v_reg;
    logic [STAGES+1:1]      rdy;

    // stage data
    cell_in_t                   in_reg;
    logic [FILM_WIDTH-1:0]      film_reg  [FACES];
    logic [TEMP_WIDTH-1:0]      absd_reg  [4:2][FACES];
    logic [TEMP_WIDTH-1:0]      absd6_reg [FACES];
    logic [TEMP_WIDTH-1:0]      absd7_reg [FACES];
    logic [FACES-1:0]           neg_reg   [2:8];
    logic [FACES-1:0]           wall_reg  [2:8];
    logic                       fluid_reg [2:11];
    logic [K_WIDTH-1:0]         lo_reg    [3:5][FACES];
    logic [DK_W-1:0]            dk_reg    [FACES];
    logic [OFF_W-1:0]           off_reg   [FACES];
    logic [FACES-1:0]           wide_reg  [3:4];
    logic [X_W-1:0]             x_reg     [FACES];
    logic [PROD_W-1:0]          prod_reg  [FACES];
    logic [K_WIDTH-1:0]         k_reg     [FACES];
    logic [MAG_W-1:0]           mag_reg   [FACES];
    logic [PART_W-1:0]          plo_reg   [FACES];
    logic [PART_W-1:0]          phi_reg   [FACES];
    logic signed [TERM_W-1:0]   term_reg  [FACES];
    logic signed [PAIR_W-1:0]   pair_reg  [3];
    logic signed [ACC_W-1:0]    acc_reg;
    heat_out_t                  out_reg;

    logic [TEMP_WIDTH-1:0] tn [FACES];
    logic [TEMP_WIDTH-1:0] tc;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                scale_reg[a] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_X_SCALE: scale_reg[0] <= cfg_data;
                REG_Y_SCALE: scale_reg[1] <= cfg_data;
                REG_Z_SCALE: scale_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage flow control: a stage loads when empty or draining
    always_comb begin
        rdy[STAGES+1] = m_ready;
        for (int i = STAGES; i >= 1; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[1];
    assign m_valid = v_reg[STAGES];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) begin
                v_reg[1] <= s_valid;
            end
            for (int i = 2; i <= STAGES; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // face lanes in wall mask order
    assign tc    = in_reg.center_temp[TEMP_WIDTH-1:0];
    assign tn[0] = in_reg.temp_x_plus[TEMP_WIDTH-1:0];
    assign tn[1] = in_reg.temp_x_minus[TEMP_WIDTH-1:0];
    assign tn[2] = in_reg.temp_y_plus[TEMP_WIDTH-1:0];
    assign tn[3] = in_reg.temp_y_minus[TEMP_WIDTH-1:0];
    assign tn[4] = in_reg.temp_z_plus[TEMP_WIDTH-1:0];
    assign tn[5] = in_reg.temp_z_minus[TEMP_WIDTH-1:0];

    // stage 1: input register
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            in_reg <= s_data;
        end
    end

    // stage 2: film sum and temperature difference
    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            fluid_reg[2] <= in_reg.center_fluid;
            wall_reg[2]  <= in_reg.wall_mask;
            for (int f = 0; f < FACES; f++) begin
                film_reg[f]    <= {1'b0, tc} + {1'b0, tn[f]};
                neg_reg[2][f]  <= tn[f] < tc;
                absd_reg[2][f] <= (tn[f] >= tc) ? tn[f] - tc : tc - tn[f];
            end
        end
    end

    // stage 3: segment select
    logic [K_WIDTH-1:0] seg_lo   [FACES];
    logic [DK_W-1:0]    seg_dk   [FACES];
    logic [OFF_W-1:0]   seg_off  [FACES];
    logic [FACES-1:0]   seg_wide;

    always_comb begin
        for (int f = 0; f < FACES; f++) begin
            logic [FILM_WIDTH:0] fz;
            fz          = {1'b0, film_reg[f]};
            seg_lo[f]   = COND_K[0];
            seg_dk[f]   = '0;
            seg_off[f]  = '0;
            seg_wide[f] = 1'b0;
            for (int j = 0; j < BREAKPOINTS; j++) begin
                if (fz >= seg_base(j)) begin
                    seg_lo[f]   = COND_K[j];
                    seg_wide[f] = j >= TABLE_POINTS - 1;
                    if (j < BREAKPOINTS - 1) begin
                        seg_dk[f]  = DK_W'(COND_K[j+1] - COND_K[j]);
                        seg_off[f] = OFF_W'(fz - seg_base(j));
                    end else begin
                        seg_dk[f]  = '0;
                        seg_off[f] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            fluid_reg[3] <= fluid_reg[2];
            wall_reg[3]  <= wall_reg[2];
            neg_reg[3]   <= neg_reg[2];
            wide_reg[3]  <= seg_wide;
            for (int f = 0; f < FACES; f++) begin
                absd_reg[3][f] <= absd_reg[2][f];
                lo_reg[3][f]   <= seg_lo[f];
                dk_reg[f]      <= seg_dk[f];
                off_reg[f]     <= seg_off[f];
            end
        end
    end

    // stage 4: slope times offset plus half step
    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            fluid_reg[4] <= fluid_reg[3];
            wall_reg[4]  <= wall_reg[3];
            neg_reg[4]   <= neg_reg[3];
            wide_reg[4]  <= wide_reg[3];
            for (int f = 0; f < FACES; f++) begin
                absd_reg[4][f] <= absd_reg[3][f];
                lo_reg[4][f]   <= lo_reg[3][f];
                x_reg[f] <= X_W'(dk_reg[f]) * X_W'(off_reg[f])
                          + (wide_reg[3][f] ? X_W'(ROM_STEP / 2) : X_W'(TABLE_STEP / 2));
            end
        end
    end

    // stage 5: step is 25 times a power of two; shift then multiply by 1/25
    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            fluid_reg[5] <= fluid_reg[4];
            wall_reg[5]  <= wall_reg[4];
            neg_reg[5]   <= neg_reg[4];
            for (int f = 0; f < FACES; f++) begin
                logic [Y_W-1:0] y;
                y = wide_reg[4][f] ? Y_W'(x_reg[f] >> 8) : Y_W'(x_reg[f] >> 7);
                absd6_reg[f]   <= absd_reg[4][f];
                lo_reg[5][f]   <= lo_reg[4][f];
                prod_reg[f]    <= PROD_W'(y) * PROD_W'(RECIP_25);
            end
        end
    end

    // stage 6: conductivity
    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            fluid_reg[6] <= fluid_reg[5];
            wall_reg[6]  <= wall_reg[5];
            neg_reg[6]   <= neg_reg[5];
            for (int f = 0; f < FACES; f++) begin
                absd7_reg[f] <= absd6_reg[f];
                k_reg[f]     <= lo_reg[5][f] + K_WIDTH'(prod_reg[f][PROD_W-1:32]);
            end
        end
    end

    // stage 7: k times temperature difference
    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            fluid_reg[7] <= fluid_reg[6];
            wall_reg[7]  <= wall_reg[6];
            neg_reg[7]   <= neg_reg[6];
            for (int f = 0; f < FACES; f++) begin
                mag_reg[f] <= MAG_W'(k_reg[f]) * MAG_W'(absd7_reg[f]);
            end
        end
    end

    // stage 8: scale product split in two halves
    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            fluid_reg[8] <= fluid_reg[7];
            wall_reg[8]  <= wall_reg[7];
            neg_reg[8]   <= neg_reg[7];
            for (int f = 0; f < FACES; f++) begin
                plo_reg[f] <= PART_W'(mag_reg[f])
                            * PART_W'(scale_reg[f/2][HALF_W-1:0]);
                phi_reg[f] <= PART_W'(mag_reg[f])
                            * PART_W'(scale_reg[f/2][SCALE_WIDTH-1:HALF_W]);
            end
        end
    end

    // stage 9: signed face term, zero where the face is not a wall
    always_ff @(posedge aclk) begin
        if (rdy[9]) begin
            fluid_reg[9] <= fluid_reg[8];
            for (int f = 0; f < FACES; f++) begin
                logic [TERM_W-1:0] t;
                t = ({(TERM_W - PART_W)'(0), phi_reg[f]} << HALF_W)
                  + {(TERM_W - PART_W)'(0), plo_reg[f]};
                if (!wall_reg[8][f]) begin
                    term_reg[f] <= '0;
                end else if (neg_reg[8][f]) begin
                    term_reg[f] <= -$signed(t);
                end else begin
                    term_reg[f] <= $signed(t);
                end
            end
        end
    end

    // stage 10: pair sums
    always_ff @(posedge aclk) begin
        if (rdy[10]) begin
            fluid_reg[10] <= fluid_reg[9];
            for (int p = 0; p < 3; p++) begin
                pair_reg[p] <= PAIR_W'(term_reg[2*p]) + PAIR_W'(term_reg[2*p+1]);
            end
        end
    end

    // stage 11: total with rounding constant
    always_ff @(posedge aclk) begin
        if (rdy[11]) begin
            fluid_reg[11] <= fluid_reg[10];
            acc_reg <= ACC_W'(pair_reg[0]) + ACC_W'(pair_reg[1]) + ACC_W'(pair_reg[2])
                     + ACC_W'(32'sh8000);
        end
    end

    // stage 12: drop fraction bits and saturate
    logic signed [SH_W-1:0] sh;
    logic                   fits;
    assign sh   = SH_W'(acc_reg >>> 16);
    assign fits = (&sh[SH_W-1:HEAT_WIDTH-1]) || !(|sh[SH_W-1:HEAT_WIDTH-1]);

    always_ff @(posedge aclk) begin
        if (rdy[12]) begin
            if (!fluid_reg[11]) begin
                out_reg.heat_rate <= '0;
                out_reg.saturated <= 1'b0;
            end else if (fits) begin
                out_reg.heat_rate <= sh[HEAT_WIDTH-1:0];
                out_reg.saturated <= 1'b0;
            end else begin
                out_reg.heat_rate <= sh[SH_W-1] ? {1'b1, {(HEAT_WIDTH-1){1'b0}}}
                                                : {1'b0, {(HEAT_WIDTH-1){1'b1}}};
                out_reg.saturated <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // a clipped result sits on one of the two limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.heat_rate == {1'b1, {(HEAT_WIDTH-1){1'b0}}} ||
             m_data.heat_rate == {1'b0, {(HEAT_WIDTH-1){1'b1}}}))
        else $error("saturated result not at a limit");

    // an empty output stage never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // an accepted input reaches the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[1])
        else $error("accepted transfer lost at first stage");

    // a stalled output stage keeps its valid and its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");
`endif

endmodule

/* tb/wcss_heat_checker.sv */
`default_nettype none

module wcss_heat_checker
    import wcss_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire cell_in_t               s_data,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire heat_out_t              m_data,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [SCALE_WIDTH-1:0] cfg_data,
    output int                          mismatch_count,
    output int                          heat_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // conductivity at 300 K .. 1200 K, then the high temperature segments, Q0.20
    localparam int GAS_K [26] = '{
        27473, 34970, 41775, 48025, 53687, 58825, 63649, 67948, 71827, 75330,
        82375, 89008, 95301, 101307, 107065, 112607, 117958, 123138,
        128166, 133054, 137816, 142461, 146999, 151438, 155785, 160046
    };
    localparam int FILM_LOW   = 9600;
    localparam int FILM_STEP  = 3200;
    localparam int FILM_MID   = FILM_LOW + FILM_STEP * 9;
    localparam int HOT_STEP   = 6400;
    localparam int HOT_SEGS   = 16;

    localparam logic signed [95:0] HEAT_MAX = (96'sd1 <<< 47) - 96'sd1;
    localparam logic signed [95:0] HEAT_MIN = -(96'sd1 <<< 47);

    logic [SCALE_WIDTH-1:0] axis_scale [3];
    heat_out_t              heat_expected [$];

    // gas conductivity at a film temperature given as a Q12.5 sum
    function automatic int film_conductivity(input int film);
        int seg;
        int off;
        if (film < FILM_LOW)
            return GAS_K[0];
        if (film < FILM_MID) begin
            seg = (film - FILM_LOW) / FILM_STEP;
            off = (film - FILM_LOW) % FILM_STEP;
            return GAS_K[seg] + ((GAS_K[seg+1] - GAS_K[seg]) * off + FILM_STEP / 2) / FILM_STEP;
        end
        seg = (film - FILM_MID) / HOT_STEP;
        if (seg >= HOT_SEGS)
            return GAS_K[9 + HOT_SEGS];
        off = (film - FILM_MID) % HOT_STEP;
        seg = seg + 9;
        return GAS_K[seg] + ((GAS_K[seg+1] - GAS_K[seg]) * off + HOT_STEP / 2) / HOT_STEP;
    endfunction

    // heat source of one cell from its wall faces
    function automatic heat_out_t cell_heat(input cell_in_t c);
        heat_out_t         r;
        logic [15:0]       nb [6];
        logic signed [95:0] acc;
        logic signed [95:0] term;
        logic [33:0]       mag;
        logic [73:0]       prod;
        int                k;
        r = '0;
        if (!c.center_fluid)
            return r;
        nb[0] = c.temp_x_plus;
        nb[1] = c.temp_x_minus;
        nb[2] = c.temp_y_plus;
        nb[3] = c.temp_y_minus;
        nb[4] = c.temp_z_plus;
        nb[5] = c.temp_z_minus;
        acc = '0;
        for (int f = 0; f < 6; f++) begin
            if (c.wall_mask[f]) begin
                k = film_conductivity(int'(c.center_temp) + int'(nb[f]));
                mag = 34'(k) * 34'(nb[f] >= c.center_temp ? nb[f] - c.center_temp
                                                          : c.center_temp - nb[f]);
                prod = 74'(mag) * 74'(axis_scale[f >> 1]);
                term = $signed({22'b0, prod});
                if (nb[f] < c.center_temp)
                    term = -term;
                acc = acc + term;
            end
        end
        acc = (acc + 96'sd32768) >>> 16;
        if (acc > HEAT_MAX) begin
            r.heat_rate = HEAT_MAX[47:0];
            r.saturated = 1'b1;
        end else if (acc < HEAT_MIN) begin
            r.heat_rate = HEAT_MIN[47:0];
            r.saturated = 1'b1;
        end else begin
            r.heat_rate = acc[47:0];
        end
        return r;
    endfunction

    assign heat_pending = heat_expected.size();

    // track scales, predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        heat_out_t want;
        if (!aresetn) begin
            axis_scale[0] = '0;
            axis_scale[1] = '0;
            axis_scale[2] = '0;
            heat_expected.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index <= REG_Z_SCALE)
                axis_scale[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                heat_expected.push_back(cell_heat(s_data));
            if (m_valid && m_ready) begin
                if (heat_expected.size() == 0) begin
                    $error("unexpected result transfer heat_rate=%0d", m_data.heat_rate);
                    mismatch_count++;
                end else begin
                    want = heat_expected.pop_front();
                    if (m_data.heat_rate !== want.heat_rate) begin
                        $error("heat_rate expected %0d got %0d",
                               want.heat_rate, m_data.heat_rate);
                        mismatch_count++;
                    end
                    if (m_data.saturated !== want.saturated) begin
                        $error("saturated expected %0b got %0b",
                               want.saturated, m_data.saturated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* tb/tb_wall_conduction_source_stencil_core.sv */
`default_nettype none

module tb_wall_conduction_source_stencil_core;
    import wcss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PHASE_CELLS = 175;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    cell_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    heat_out_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [SCALE_WIDTH-1:0] cfg_data;
    int                     mismatch_count;
    int                     heat_pending;
    int                     idle_pct;
    int                     stall_pct;
    int                     quiet_cycles;

    wall_conduction_source_stencil_core dut (.*);

    wcss_heat_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (stall_pct > 0)
            m_ready <= ($urandom_range(99) >= stall_pct);
        else
            m_ready <= 1'b1;
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cell(input cell_in_t c);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (heat_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [1:0] idx, input logic [SCALE_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [SCALE_WIDTH-1:0] pick_scale();
        case ($urandom_range(3))
            0: return {8'($urandom), 32'($urandom)};
            1: return 40'($urandom_range(4095));
            2: return 40'($urandom_range(24'hFFFFFF));
            default: return {SCALE_WIDTH{1'b1}};
        endcase
    endfunction

    function automatic cell_in_t make_cell(input logic [15:0] tc, input logic [15:0] tn,
                                           input logic fluid, input logic [5:0] mask);
        cell_in_t c;
        c.center_temp  = tc;
        c.temp_x_plus  = tn;
        c.temp_x_minus = tn;
        c.temp_y_plus  = tn;
        c.temp_y_minus = tn;
        c.temp_z_plus  = tn;
        c.temp_z_minus = tn;
        c.center_fluid = fluid;
        c.wall_mask    = mask;
        return c;
    endfunction

    // mostly plausible gas temperatures near the cell, some anywhere
    function automatic logic [15:0] neighbor_temp(input logic [15:0] tc);
        int t;
        if ($urandom_range(9) < 3)
            return 16'($urandom);
        t = int'(tc) + $urandom_range(8000) - 4000;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return 16'(t);
    endfunction

    function automatic cell_in_t random_cell();
        cell_in_t c;
        c.center_temp  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(2000, 40000));
        c.temp_x_plus  = neighbor_temp(c.center_temp);
        c.temp_x_minus = neighbor_temp(c.center_temp);
        c.temp_y_plus  = neighbor_temp(c.center_temp);
        c.temp_y_minus = neighbor_temp(c.center_temp);
        c.temp_z_plus  = neighbor_temp(c.center_temp);
        c.temp_z_minus = neighbor_temp(c.center_temp);
        c.center_fluid = ($urandom_range(9) != 0);
        c.wall_mask    = 6'($urandom);
        return c;
    endfunction

    initial begin
        cell_in_t c;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_SCALE;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed cells at moderate scales
        write_scale(REG_X_SCALE, 40'd256);
        write_scale(REG_Y_SCALE, 40'd1000);
        write_scale(REG_Z_SCALE, 40'd77777);
        write_scale(REG_UNUSED, {SCALE_WIDTH{1'b1}});
        send_cell(make_cell(16'd0, 16'd0, 1'b1, 6'h3F));
        send_cell(make_cell(16'hFFFF, 16'hFFFF, 1'b1, 6'h3F));
        send_cell(make_cell(16'd0, 16'hFFFF, 1'b1, 6'h3F));
        send_cell(make_cell(16'hFFFF, 16'd0, 1'b1, 6'h3F));
        send_cell(make_cell(16'd4800, 16'd4800, 1'b1, 6'h3F));
        send_cell(make_cell(16'd4000, 16'd5600, 1'b1, 6'h3F));
        send_cell(make_cell(16'd4000, 16'd5599, 1'b1, 6'h3F));
        send_cell(make_cell(16'd19200, 16'd19200, 1'b1, 6'h3F));
        send_cell(make_cell(16'd18000, 16'd20401, 1'b1, 6'h3F));
        send_cell(make_cell(16'd30000, 16'd50000, 1'b1, 6'h3F));
        send_cell(make_cell(16'd1000, 16'd60000, 1'b0, 6'h3F));
        send_cell(make_cell(16'd1000, 16'd60000, 1'b1, 6'h00));
        for (int f = 0; f < 6; f++) begin
            c = make_cell(16'd5000, 16'd5000, 1'b1, 6'(1 << f));
            c.temp_x_plus  = 16'd9000;
            c.temp_x_minus = 16'd1000;
            c.temp_y_plus  = 16'd12000;
            c.temp_y_minus = 16'd100;
            c.temp_z_plus  = 16'd40000;
            c.temp_z_minus = 16'd4999;
            send_cell(c);
        end
        wait_drained();

        // random phases with varied scales and flow control
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                write_scale(REG_X_SCALE, {SCALE_WIDTH{1'b1}});
                write_scale(REG_Y_SCALE, {SCALE_WIDTH{1'b1}});
                write_scale(REG_Z_SCALE, {SCALE_WIDTH{1'b1}});
            end else if (phase == 1) begin
                write_scale(REG_X_SCALE, '0);
                write_scale(REG_Y_SCALE, '0);
                write_scale(REG_Z_SCALE, '0);
            end else begin
                write_scale(REG_X_SCALE, pick_scale());
                write_scale(REG_Y_SCALE, pick_scale());
                write_scale(REG_Z_SCALE, pick_scale());
            end
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            for (int i = 0; i < PHASE_CELLS; i++) begin
                // in phase 3, let the pipeline empty once mid-phase
                if (phase == 3 && i == PHASE_CELLS / 2)
                    wait_drained();
                send_cell(random_cell());
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/wcss_pkg.sv
rtl/wall_conduction_source_stencil_core.sv
tb/wcss_heat_checker.sv
tb/tb_wall_conduction_source_stencil_core.sv
